/* rtl/core/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros
// shared concurrent assertion macros
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent implies consequent on the next clock edge
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/rkc_pkg.sv */
// ---------------------------------------------------------------------------
// rkc_pkg
// shared types and constants of the rgb kernel convolution block
// ---------------------------------------------------------------------------
package rkc_pkg;

    localparam int MaxWidth     = 1024;
    localparam int MaxKernel    = 5;
    localparam int CoefFracBits = 12;
    localparam int HeightLimit  = 1024;

    localparam int ColW   = $clog2(MaxWidth);
    localparam int RowW   = $clog2(HeightLimit);
    localparam int KW     = 3;
    localparam int SlotW  = 3;
    localparam int CoefN  = MaxKernel * MaxKernel;
    localparam int CIdxW  = 5;
    localparam int LineN  = MaxKernel * MaxWidth;
    localparam int LAddrW = $clog2(LineN);
    localparam int AccW   = 40;

    localparam logic [2:0] RegWidth  = 3'd0;
    localparam logic [2:0] RegHeight = 3'd1;
    localparam logic [2:0] RegKCols  = 3'd2;
    localparam logic [2:0] RegKRows  = 3'd3;
    localparam logic [2:0] RegMode   = 3'd4;

    localparam logic FuncCoef  = 1'b0;
    localparam logic FuncPixel = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MAC,
        ST_DRAIN,
        ST_POST,
        ST_OUT
    } state_t;

    function automatic logic [7:0] post_mag(input logic signed [AccW-1:0] acc);
        logic [AccW-1:0] mag;
        logic [AccW-1:0] sh;
        begin
            mag = acc[AccW-1] ? AccW'(-acc) : AccW'(acc);
            sh  = mag >> CoefFracBits;
            post_mag = (sh > AccW'(255)) ? 8'd255 : sh[7:0];
        end
    endfunction

endpackage

/* rtl/core/rgb_kernel_convolution_top.sv */
// ---------------------------------------------------------------------------
// rgb_kernel_convolution_top
// valid-region 2d convolution of an rgb stream with a flipped kernel
// ---------------------------------------------------------------------------
// channel   dir  contents
// s_axis    in   tdata {pix_blue,pix_green,pix_red,coef_value,coef_index}, tuser func
// m_axis    out  tdata {out_blue,out_green,out_red}, tlast frame_end
// cfg       in   cfg_we, cfg_addr, cfg_wdata
//
// coefficient items and pixel items that make no result are taken without leaving idle;
// a window steps through its taps in the read state, one line-store read
// and one multiply per channel per tap through the shared mac, then drains.
// reset is asynchronous; line and coefficient stores need no clearing.
// a result waits in the output register; the next item is taken meanwhile,
// and a second result holds the input until the register drains.
// ---------------------------------------------------------------------------
module rgb_kernel_convolution_top
    import rkc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // coef_index, coef_value, pix_red, pix_green, pix_blue
    input  logic        s_axis_tuser,   // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // out_red, out_green, out_blue
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [10:0] cfg_wdata
);

    logic [10:0] width_reg, height_reg;
    logic [2:0]  kcols_reg, krows_reg;
    logic        mode_reg;
    logic [ColW-1:0] col_reg;
    logic [RowW-1:0] row_reg;
    logic [SlotW-1:0] slot_reg;

    logic [23:0] line_mem [LineN];
    logic signed [15:0] coef_mem [CoefN];
    logic [23:0] line_rd;
    logic signed [15:0] coef_rd;

    state_t state_reg, state_next;

    logic [KW-1:0] k_reg, l_reg;
    logic [SlotW-1:0] top_slot_reg;
    logic [ColW-1:0] left_reg;
    logic [KW-1:0] kc_reg, kr_reg;
    logic last_reg;
    logic rd_v_reg;
    logic signed [AccW-1:0] acc_r_reg, acc_g_reg, acc_b_reg;
    logic signed [24:0] prod_r_reg, prod_g_reg, prod_b_reg;
    logic prod_v_reg;
    logic [7:0] res_r_reg, res_g_reg, res_b_reg;
    logic obuf_full_reg;
    logic [23:0] obuf_data_reg;
    logic obuf_last_reg;

    // effective geometry
    logic [ColW:0] w_eff;
    logic [RowW:0] h_eff;
    logic [KW-1:0] kc_eff, kr_eff;
    always_comb
    begin
        w_eff  = (width_reg == 11'd0) ? (ColW+1)'(1) :
                 (width_reg > 11'(MaxWidth)) ? (ColW+1)'(MaxWidth) : width_reg[ColW:0];
        h_eff  = (height_reg == 11'd0) ? (RowW+1)'(1) :
                 (height_reg > 11'(HeightLimit)) ? (RowW+1)'(HeightLimit) : height_reg[RowW:0];
        kc_eff = (kcols_reg == 3'd0) ? 3'd1 : (kcols_reg > 3'(MaxKernel)) ? 3'(MaxKernel) : kcols_reg;
        kr_eff = (krows_reg == 3'd0) ? 3'd1 : (krows_reg > 3'(MaxKernel)) ? 3'(MaxKernel) : krows_reg;
    end

    logic        in_func;
    logic [4:0]  in_cidx;
    logic [15:0] in_cval;
    logic [23:0] in_pix;
    assign in_func = s_axis_tuser;
    assign in_cidx = s_axis_tdata[4:0];
    assign in_cval = s_axis_tdata[20:5];
    // pixel packing: red high byte, green middle, blue low
    assign in_pix  = {s_axis_tdata[28:21], s_axis_tdata[36:29], s_axis_tdata[44:37]};

    assign s_axis_tready = (state_reg == ST_IDLE);
    logic acc_in;
    assign acc_in = s_axis_tvalid && s_axis_tready;

    logic [ColW-1:0] col_c;
    logic [RowW-1:0] row_c;
    always_comb
    begin
        col_c = ({1'b0, col_reg} >= w_eff) ? '0 : col_reg;
        row_c = ({1'b0, row_reg} >= h_eff) ? '0 : row_reg;
    end

    // line slot of the current row, kept alongside the row counter
    logic [SlotW-1:0] wr_slot;
    assign wr_slot = ({1'b0, row_reg} >= h_eff) ? '0 : slot_reg;

    logic emit_c, last_c, col_end_c, row_end_c;
    always_comb
    begin
        emit_c    = ({1'b0, row_c} + 1'b1 >= (RowW+1)'(kr_eff)) &&
                    ({1'b0, col_c} + 1'b1 >= (ColW+1)'(kc_eff));
        col_end_c = ({1'b0, col_c} + 1'b1 >= w_eff);
        row_end_c = ({1'b0, row_c} + 1'b1 >= h_eff);
        last_c    = col_end_c && row_end_c;
    end

    // slot of the window's top row
    logic [SlotW:0] tslot_sum;
    logic [SlotW-1:0] top_slot_c;
    always_comb
    begin
        tslot_sum  = {1'b0, wr_slot} + (SlotW+1)'(MaxKernel + 1) - {1'b0, kr_eff};
        top_slot_c = (tslot_sum >= (SlotW+1)'(MaxKernel)) ?
                     SlotW'(tslot_sum - (SlotW+1)'(MaxKernel)) : tslot_sum[SlotW-1:0];
    end

    logic [SlotW:0] rd_sum;
    logic [SlotW-1:0] rd_slot;
    logic [LAddrW-1:0] rd_addr, wr_addr;
    logic [CIdxW-1:0] cf_addr;
    logic rd_en;
    always_comb
    begin
        rd_sum  = {1'b0, top_slot_reg} + {1'b0, k_reg};
        rd_slot = (rd_sum >= (SlotW+1)'(MaxKernel)) ?
                  SlotW'(rd_sum - (SlotW+1)'(MaxKernel)) : rd_sum[SlotW-1:0];
        rd_addr = LAddrW'(rd_slot) * LAddrW'(MaxWidth) + LAddrW'(left_reg) + LAddrW'(l_reg);
        cf_addr = CIdxW'((kr_reg - 3'd1 - k_reg)) * CIdxW'(MaxKernel) +
                  CIdxW'(kc_reg - 3'd1 - l_reg);
        wr_addr = LAddrW'(wr_slot) * LAddrW'(MaxWidth) + LAddrW'(col_c);
        rd_en   = (state_reg == ST_READ);
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (acc_in && in_func == FuncPixel)
            line_mem[wr_addr] <= in_pix;
        if (rd_en)
            line_rd <= line_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (acc_in && in_func == FuncCoef && in_cidx < 5'(CoefN))
            coef_mem[in_cidx] <= in_cval;
        if (rd_en)
            coef_rd <= coef_mem[cf_addr];
    end

    logic tap_last;
    assign tap_last = (k_reg == kr_reg - 3'd1) && (l_reg == kc_reg - 3'd1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (acc_in && in_func == FuncPixel && emit_c) state_next = ST_READ;
            ST_READ:  if (tap_last) state_next = ST_DRAIN;
            ST_MAC:   state_next = ST_DRAIN;
            ST_DRAIN: if (!rd_v_reg && !prod_v_reg) state_next = ST_POST;
            ST_POST:  state_next = ST_OUT;
            ST_OUT:   if (!obuf_full_reg || m_axis_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            width_reg     <= 11'd640;
            height_reg    <= 11'd480;
            kcols_reg     <= 3'd3;
            krows_reg     <= 3'd3;
            mode_reg      <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            slot_reg      <= '0;
            rd_v_reg      <= 1'b0;
            prod_v_reg    <= 1'b0;
            obuf_full_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_v_reg   <= rd_en;
            prod_v_reg <= rd_v_reg;
            if (cfg_we)
            begin
                case (cfg_addr)
                    RegWidth:
                    begin
                        width_reg <= cfg_wdata;
                        col_reg <= '0; row_reg <= '0; slot_reg <= '0;
                    end
                    RegHeight:
                    begin
                        height_reg <= cfg_wdata;
                        col_reg <= '0; row_reg <= '0; slot_reg <= '0;
                    end
                    RegKCols:
                    begin
                        kcols_reg <= cfg_wdata[2:0];
                        col_reg <= '0; row_reg <= '0; slot_reg <= '0;
                    end
                    RegKRows:
                    begin
                        krows_reg <= cfg_wdata[2:0];
                        col_reg <= '0; row_reg <= '0; slot_reg <= '0;
                    end
                    RegMode:   mode_reg <= cfg_wdata[0];
                    default:   ;
                endcase
            end
            else if (acc_in && in_func == FuncPixel)
            begin
                if (col_end_c)
                begin
                    col_reg  <= '0;
                    row_reg  <= row_end_c ? '0 : row_c + 1'b1;
                    slot_reg <= (row_end_c || wr_slot == SlotW'(MaxKernel - 1)) ? '0 :
                                wr_slot + 1'b1;
                end
                else
                begin
                    col_reg  <= col_c + 1'b1;
                    row_reg  <= row_c;
                    slot_reg <= wr_slot;
                end
            end
            if (state_reg == ST_OUT && (!obuf_full_reg || m_axis_tready))
                obuf_full_reg <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready)
                obuf_full_reg <= 1'b0;
        end
    end

    // window sequencing and mac datapath
    always_ff @(posedge clk)
    begin
        if (acc_in && in_func == FuncPixel && emit_c)
        begin
            top_slot_reg <= top_slot_c;
            left_reg     <= col_c + 1'b1 - ColW'(kc_eff);
            kc_reg       <= kc_eff;
            kr_reg       <= kr_eff;
            last_reg     <= last_c;
            k_reg        <= '0;
            l_reg        <= '0;
            acc_r_reg    <= '0;
            acc_g_reg    <= '0;
            acc_b_reg    <= '0;
        end
        else
        begin
            if (rd_en)
            begin
                if (l_reg == kc_reg - 3'd1)
                begin
                    l_reg <= '0;
                    k_reg <= k_reg + 1'b1;
                end
                else
                    l_reg <= l_reg + 1'b1;
            end
            if (prod_v_reg)
            begin
                acc_r_reg <= acc_r_reg + AccW'(prod_r_reg);
                acc_g_reg <= acc_g_reg + AccW'(prod_g_reg);
                acc_b_reg <= acc_b_reg + AccW'(prod_b_reg);
            end
        end
        if (rd_v_reg)
        begin
            prod_r_reg <= coef_rd * $signed({1'b0, line_rd[23:16]});
            prod_g_reg <= coef_rd * $signed({1'b0, line_rd[15:8]});
            prod_b_reg <= coef_rd * $signed({1'b0, line_rd[7:0]});
        end
        if (state_reg == ST_POST)
        begin
            res_r_reg <= post_mag(acc_r_reg);
            res_g_reg <= post_mag(acc_g_reg);
            res_b_reg <= post_mag(acc_b_reg);
        end
    end

    logic [7:0] mx;
    always_comb
    begin
        mx = res_r_reg;
        if (res_g_reg > mx) mx = res_g_reg;
        if (res_b_reg > mx) mx = res_b_reg;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && (!obuf_full_reg || m_axis_tready))
        begin
            obuf_data_reg <= mode_reg ? {mx, mx, mx} : {res_b_reg, res_g_reg, res_r_reg};
            obuf_last_reg <= last_reg;
        end
    end

    assign m_axis_tvalid = obuf_full_reg;
    assign m_axis_tdata  = obuf_data_reg;
    assign m_axis_tlast  = obuf_last_reg;

    `include "assert_macros.svh"

    `ASSERT_ALWAYS(a_ready_idle, s_axis_tready == (state_reg == ST_IDLE), "ready outside idle")
    `ASSERT_NEXT(a_read_pipe, rd_v_reg, prod_v_reg, "product stage skipped")
    `ASSERT_NEXT(a_out_fill, state_reg == ST_OUT && !obuf_full_reg, obuf_full_reg,
                 "result not registered")

endmodule

/* tb/rgb_kernel_convolution_top_test.sv */
// ---------------------------------------------------------------------------
// rgb_kernel_convolution_top_test
// self-checking bench for the rgb kernel convolution block
// ---------------------------------------------------------------------------
// loads kernels, streams raster pixels through several image and kernel
// geometries, and checks every output pixel against a behavioral model of the
// flipped-kernel valid-region convolution and its clamp and max post steps
// ---------------------------------------------------------------------------
module rgb_kernel_convolution_top_test;
    import rkc_pkg::*;

    typedef struct {
        logic               func;
        logic [4:0]         cidx;
        logic signed [15:0] cval;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
    } item_t;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } pix_out_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] in_word;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [10:0] cfg_wdata;

    item_t       pending_items[$];
    pix_out_t    expected_pixels[$];
    item_t       cur_item;
    bit          took;
    int          send_idle;
    int          recv_idle;
    int          errors;
    int          items_queued;

    // behavioral state
    logic [23:0]        line_mem[MaxKernel][MaxWidth];
    logic signed [15:0] kernel[CoefN];
    int                 col_pos;
    int                 row_pos;
    int                 img_w;
    int                 img_h;
    int                 k_cols;
    int                 k_rows;
    int                 gray_mode;

    rgb_kernel_convolution_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (in_word),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int clamp_int(int v, int lo, int hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic logic [7:0] sat_mag(longint acc);
        longint mag;
        begin
            mag = (acc < 0) ? -acc : acc;
            mag = mag >>> CoefFracBits;
            return (mag > 255) ? 8'd255 : mag[7:0];
        end
    endfunction

    task automatic conv_predict(item_t it);
        int       w, h, kc, kr, col, row;
        int       top, left;
        bit       emit, last;
        longint   acc[3];
        logic [23:0] px;
        longint   cf;
        logic [7:0] mx;
        pix_out_t res;
        begin
            if (it.func == FuncCoef)
            begin
                if (it.cidx < CoefN)
                    kernel[it.cidx] = it.cval;
                return;
            end
            w = clamp_int(img_w, 1, MaxWidth);
            h = clamp_int(img_h, 1, HeightLimit);
            kc = clamp_int(k_cols, 1, MaxKernel);
            kr = clamp_int(k_rows, 1, MaxKernel);
            col = (col_pos >= w) ? 0 : col_pos;
            row = (row_pos >= h) ? 0 : row_pos;
            line_mem[row % MaxKernel][col] = {it.red, it.green, it.blue};
            emit = (row + 1 >= kr) && (col + 1 >= kc);
            last = (row + 1 == h) && (col + 1 == w);
            if (col + 1 >= w)
            begin
                col_pos = 0;
                row_pos = (row + 1 >= h) ? 0 : row + 1;
            end
            else
            begin
                col_pos = col + 1;
                row_pos = row;
            end
            if (!emit)
                return;
            top = row + 1 - kr;
            left = col + 1 - kc;
            acc = '{0, 0, 0};
            for (int k = 0; k < kr; k++)
                for (int l = 0; l < kc; l++)
                begin
                    px = line_mem[(top + k) % MaxKernel][left + l];
                    cf = kernel[(kr - 1 - k) * MaxKernel + (kc - 1 - l)];
                    acc[0] += cf * longint'(px[23:16]);
                    acc[1] += cf * longint'(px[15:8]);
                    acc[2] += cf * longint'(px[7:0]);
                end
            res.red = sat_mag(acc[0]);
            res.green = sat_mag(acc[1]);
            res.blue = sat_mag(acc[2]);
            if (gray_mode)
            begin
                mx = res.red;
                if (res.green > mx)
                    mx = res.green;
                if (res.blue > mx)
                    mx = res.blue;
                res.red = mx;
                res.green = mx;
                res.blue = mx;
            end
            res.last = last;
            expected_pixels.push_back(res);
        end
    endtask

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_axis_tvalid || took)
            begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle)
                begin
                    cur_item = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= cur_item.func;
                    in_word <= {3'b000, cur_item.blue, cur_item.green, cur_item.red,
                                cur_item.cval, cur_item.cidx};
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        took = s_axis_tvalid && s_axis_tready;
        if (took)
            conv_predict(cur_item);
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("output item with nothing expected");
                errors++;
            end
            else
            begin
                pix_out_t e;
                e = expected_pixels.pop_front();
                if (m_axis_tdata[7:0] !== e.red)
                begin
                    $error("out_red expected %0d actual %0d", e.red, m_axis_tdata[7:0]);
                    errors++;
                end
                if (m_axis_tdata[15:8] !== e.green)
                begin
                    $error("out_green expected %0d actual %0d", e.green, m_axis_tdata[15:8]);
                    errors++;
                end
                if (m_axis_tdata[23:16] !== e.blue)
                begin
                    $error("out_blue expected %0d actual %0d", e.blue, m_axis_tdata[23:16]);
                    errors++;
                end
                if (m_axis_tlast !== e.last)
                begin
                    $error("frame_end expected %0d actual %0d", e.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    task automatic reg_write(logic [2:0] addr, int value);
        begin
            @(negedge clk);
            cfg_we <= 1'b1;
            cfg_addr <= addr;
            cfg_wdata <= value[10:0];
            @(negedge clk);
            cfg_we <= 1'b0;
            case (addr)
                RegWidth:  img_w = value & 11'h7ff;
                RegHeight: img_h = value & 11'h7ff;
                RegKCols:  k_cols = value & 3'h7;
                RegKRows:  k_rows = value & 3'h7;
                default:   gray_mode = value & 1;
            endcase
            if (addr != RegMode)
            begin
                col_pos = 0;
                row_pos = 0;
            end
        end
    endtask

    task automatic set_geometry(int w, int h, int kc, int kr, int mode);
        begin
            reg_write(RegWidth, w);
            reg_write(RegHeight, h);
            reg_write(RegKCols, kc);
            reg_write(RegKRows, kr);
            reg_write(RegMode, mode);
        end
    endtask

    task automatic queue_coef(int idx, int value);
        item_t it;
        begin
            it.func = FuncCoef;
            it.cidx = idx[4:0];
            it.cval = value[15:0];
            it.red = $urandom;
            it.green = $urandom;
            it.blue = $urandom;
            pending_items.push_back(it);
            items_queued++;
        end
    endtask

    task automatic queue_pixel(int r, int g, int b);
        item_t it;
        begin
            it.func = FuncPixel;
            it.cidx = $urandom;
            it.cval = $urandom;
            it.red = r[7:0];
            it.green = g[7:0];
            it.blue = b[7:0];
            pending_items.push_back(it);
            items_queued++;
        end
    endtask

    task automatic queue_random_pixels(int n);
        begin
            for (int i = 0; i < n; i++)
                queue_pixel($urandom, $urandom, $urandom);
        end
    endtask

    task automatic wait_drained();
        begin
            while (pending_items.size() > 0 || s_axis_tvalid || expected_pixels.size() > 0)
                @(posedge clk);
            repeat (60) @(posedge clk);
        end
    endtask

    task automatic pick_idling();
        begin
            if (items_queued < 600)
            begin
                send_idle = 16;
                recv_idle = 60;
            end
            else if (items_queued < 1200)
            begin
                send_idle = 60;
                recv_idle = 16;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
        end
    endtask

    initial
    begin
        int w, h, span;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser = 1'b0;
        in_word = '0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        took = 0;
        errors = 0;
        items_queued = 0;
        col_pos = 0;
        row_pos = 0;
        img_w = 640;
        img_h = 480;
        k_cols = 3;
        k_rows = 3;
        gray_mode = 0;
        foreach (kernel[i])
            kernel[i] = '0;
        pick_idling();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // single tap at the coefficient extremes, saturation and zero pixels
        set_geometry(4, 3, 1, 1, 0);
        queue_coef(0, 32767);
        queue_coef(31, -1);
        queue_pixel(255, 255, 255);
        queue_pixel(0, 0, 0);
        queue_pixel(1, 16, 32);
        queue_random_pixels(9);
        wait_drained();
        set_geometry(3, 3, 1, 1, 1);
        queue_coef(0, -32768);
        queue_coef(25, 4096);
        queue_pixel(0, 255, 0);
        queue_pixel(0, 0, 0);
        queue_random_pixels(7);
        wait_drained();
        // kernel larger than the image: nothing comes out
        set_geometry(2, 2, 5, 5, 0);
        queue_random_pixels(6);
        wait_drained();

        // widest row, register value beyond the clamp
        set_geometry(2047, 1, 3, 1, 0);
        for (int i = 0; i < CoefN; i++)
            queue_coef(i, $urandom_range(0, 2048) - 1024);
        queue_random_pixels(1030);
        wait_drained();
        // tallest image with zero width and oversized kernel rows
        pick_idling();
        set_geometry(0, 2047, 0, 7, 1);
        queue_random_pixels(30);
        wait_drained();

        while (items_queued < 1750)
        begin
            pick_idling();
            w = $urandom_range(1, 10);
            h = $urandom_range(1, 8);
            set_geometry(w, h, $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 1));
            span = ($urandom_range(0, 1) == 0) ? 1024 : 32768;
            for (int i = 0; i < CoefN; i++)
                queue_coef(i, $urandom_range(0, 2 * span - 1) - span);
            if ($urandom_range(0, 3) == 0)
                queue_coef($urandom_range(CoefN, 31), $urandom);
            queue_random_pixels(w * h * $urandom_range(1, 2) + $urandom_range(0, w));
            wait_drained();
        end

        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #30_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/rkc_pkg.sv
rtl/core/rgb_kernel_convolution_top.sv
tb/rgb_kernel_convolution_top_test.sv
